// File: rtl/srss_pkg.sv
package srss_pkg;

  // Row capacity and the number of column bits that are kept.
  localparam int ROW_CAPACITY = 64;
  localparam int COLUMN_BITS  = 16;

  // Derived widths.
  localparam int ADDR_W = $clog2(ROW_CAPACITY);
  localparam int CNT_W  = $clog2(ROW_CAPACITY + 1);

  // Fixed field widths of the channels.
  localparam int KIND_W      = 2;
  localparam int COL_IN_W    = 16;
  localparam int VALUE_W     = 32;
  localparam int COUNT_OUT_W = 7;

  // Operation codes.
  localparam logic [KIND_W-1:0] KIND_GET    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Request from the sequencer to the entry memory.
  typedef struct packed {
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [COLUMN_BITS-1:0] wcol;
    logic [VALUE_W-1:0]     wval;
    logic [ADDR_W-1:0]      raddr;
  } mem_req_t;

  // Registered read data of the entry memory.
  typedef struct packed {
    logic [COLUMN_BITS-1:0] col;
    logic [VALUE_W-1:0]     val;
  } mem_rd_t;

  // Result of one operation.
  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic               found;
    logic               overflow;
    logic [CNT_W-1:0]   count;
  } result_t;

endpackage

// File: rtl/srss_if.sv
interface srss_in_if;
  logic                           valid;
  logic                           ready;
  logic [srss_pkg::KIND_W-1:0]    kind;
  logic [srss_pkg::COL_IN_W-1:0]  column;
  logic [srss_pkg::VALUE_W-1:0]   value;

  modport source (output valid, kind, column, value, input ready);
  modport sink   (input valid, kind, column, value, output ready);
endinterface

interface srss_out_if;
  logic                              valid;
  logic                              ready;
  logic [srss_pkg::VALUE_W-1:0]      read_value;
  logic                              found;
  logic                              overflow;
  logic [srss_pkg::COUNT_OUT_W-1:0]  entry_count;

  modport source (output valid, read_value, found, overflow, entry_count, input ready);
  modport sink   (input valid, read_value, found, overflow, entry_count, output ready);
endinterface

// File: rtl/srss_mem.sv
module srss_mem (
  input  logic               clk,
  input  srss_pkg::mem_req_t req,
  output srss_pkg::mem_rd_t  rd
);

  logic [srss_pkg::COLUMN_BITS-1:0] col_mem [srss_pkg::ROW_CAPACITY];
  logic [srss_pkg::VALUE_W-1:0]     val_mem [srss_pkg::ROW_CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      col_mem[req.waddr] <= req.wcol;
      val_mem[req.waddr] <= req.wval;
    end
    rd.col <= col_mem[req.raddr];
    rd.val <= val_mem[req.raddr];
  end

endmodule

// File: rtl/srss_ctrl.sv
module srss_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [srss_pkg::KIND_W-1:0]     in_kind,
  input  logic [srss_pkg::COL_IN_W-1:0]   in_column,
  input  logic [srss_pkg::VALUE_W-1:0]    in_value,
  input  logic                            out_free,
  output logic                            res_valid,
  output srss_pkg::result_t               res,
  output srss_pkg::mem_req_t              req,
  input  srss_pkg::mem_rd_t               rd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SRCH = 9'b000000010,
    S_CMP  = 9'b000000100,
    S_CHK  = 9'b000001000,
    S_CHKC = 9'b000010000,
    S_ACT  = 9'b000100000,
    S_SHRD = 9'b001000000,
    S_SHWR = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [srss_pkg::KIND_W-1:0]      kind_r, kind_nxt;
  logic [srss_pkg::COLUMN_BITS-1:0] key_r, key_nxt;
  logic [srss_pkg::VALUE_W-1:0]     val_r, val_nxt;
  logic [srss_pkg::CNT_W-1:0]       lo_r, lo_nxt;
  logic [srss_pkg::CNT_W-1:0]       hi_r, hi_nxt;
  logic [srss_pkg::ADDR_W-1:0]      mid_r, mid_nxt;
  logic [srss_pkg::CNT_W-1:0]       k_r, k_nxt;
  logic [srss_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic                             found_r, found_nxt;
  logic                             ovf_r, ovf_nxt;
  logic [srss_pkg::VALUE_W-1:0]     rval_r, rval_nxt;
  logic [srss_pkg::CNT_W:0]         mid_sum;
  logic [srss_pkg::ADDR_W-1:0]      mid_w;
  logic [srss_pkg::CNT_W-1:0]       k_dec;
  logic                             col_lt;
  logic                             col_eq;

  // Midpoint of the remaining search window; it is always below the capacity.
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_w   = srss_pkg::ADDR_W'(mid_sum >> 1);
  assign k_dec   = k_r - srss_pkg::CNT_W'(1);

  // The one shared comparator, fed by the registered memory read.
  assign col_lt = rd.col < key_r;
  assign col_eq = rd.col == key_r;

  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign res_valid = (state_r == S_DONE);
  assign res.read_value = rval_r;
  assign res.found      = found_r;
  assign res.overflow   = ovf_r;
  assign res.count      = count_r;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    k_nxt     = k_r;
    count_nxt = count_r;
    found_nxt = found_r;
    ovf_nxt   = ovf_r;
    rval_nxt  = rval_r;
    req.we    = 1'b0;
    req.waddr = lo_r[srss_pkg::ADDR_W-1:0];
    req.wcol  = key_r;
    req.wval  = val_r;
    req.raddr = mid_w;

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          kind_nxt  = in_kind;
          key_nxt   = srss_pkg::COLUMN_BITS'(in_column);
          val_nxt   = in_value;
          lo_nxt    = '0;
          hi_nxt    = count_r;
          found_nxt = 1'b0;
          ovf_nxt   = 1'b0;
          rval_nxt  = '0;
          state_nxt = (in_kind == srss_pkg::KIND_UNUSED) ? S_DONE : S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          req.raddr = mid_w;
          mid_nxt   = mid_w;
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_CMP: begin
        if (col_lt) begin
          lo_nxt = srss_pkg::CNT_W'(mid_r) + srss_pkg::CNT_W'(1);
        end else begin
          hi_nxt = srss_pkg::CNT_W'(mid_r);
        end
        state_nxt = S_SRCH;
      end
      S_CHK: begin
        if (lo_r < count_r) begin
          req.raddr = lo_r[srss_pkg::ADDR_W-1:0];
          state_nxt = S_CHKC;
        end else begin
          state_nxt = S_ACT;
        end
      end
      S_CHKC: begin
        found_nxt = col_eq;
        if (col_eq && (kind_r == srss_pkg::KIND_GET)) begin
          rval_nxt = rd.val;
        end
        state_nxt = S_ACT;
      end
      S_ACT: begin
        state_nxt = S_DONE;
        case (kind_r)
          srss_pkg::KIND_SET: begin
            if (found_r) begin
              req.we = 1'b1;
            end else if (count_r == srss_pkg::CNT_W'(srss_pkg::ROW_CAPACITY)) begin
              ovf_nxt = 1'b1;
            end else begin
              k_nxt     = count_r;
              state_nxt = S_SHRD;
            end
          end
          srss_pkg::KIND_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      S_SHRD: begin
        if (k_r > lo_r) begin
          req.raddr = k_dec[srss_pkg::ADDR_W-1:0];
          state_nxt = S_SHWR;
        end else begin
          req.we    = 1'b1;
          count_nxt = count_r + srss_pkg::CNT_W'(1);
          state_nxt = S_DONE;
        end
      end
      S_SHWR: begin
        req.we    = 1'b1;
        req.waddr = k_r[srss_pkg::ADDR_W-1:0];
        req.wcol  = rd.col;
        req.wval  = rd.val;
        k_nxt     = k_dec;
        state_nxt = S_SHRD;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    kind_r  <= kind_nxt;
    key_r   <= key_nxt;
    val_r   <= val_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    k_r     <= k_nxt;
    found_r <= found_nxt;
    ovf_r   <= ovf_nxt;
    rval_r  <= rval_nxt;
  end

endmodule

// File: rtl/sparse_row_sorted_store_core.sv
// Sorted sparse row store: one matrix row held as up to 64 entries sorted by
// column, each a column index and a 32-bit value.
// Input channel in_ch carries a transaction of kind (get, set, clear), column
// and value. Result channel out_ch returns one transaction per input: the
// value read by a get (zero if absent), found, overflow for a set into a full
// row, and the entry count after the operation.
// Each transaction runs one at a time through a small sequencer around one
// column comparator and a single-port-write entry memory with registered
// reads. The lookup is a binary search; each step reads the middle entry and
// then compares its column with the key. A set that inserts a new column also
// moves every larger entry up by one, a read and then a write per moved entry,
// so its cost grows with the entries behind it. A kind code of 3 skips the
// search and is answered with a zero value, found and overflow clear, and the
// unchanged entry count.
// The next transaction is accepted in the cycle after the result is taken.
// Reset empties the row at once; the memory itself is not cleared, since
// only entries below the count are ever read. No clearing pass is needed.
// While the receiver stalls, the result waits in the output register and no
// new transaction is accepted until it has been taken.
module sparse_row_sorted_store_core (
  input  logic       clk,
  input  logic       rst_n,
  srss_in_if.sink    in_ch,
  srss_out_if.source out_ch
);

  srss_pkg::mem_req_t mem_req;
  srss_pkg::mem_rd_t  mem_rd;
  srss_pkg::result_t  res;
  logic               res_valid;
  logic               out_valid_r, out_valid_nxt;
  srss_pkg::result_t  out_res_r, out_res_nxt;

  // Sequencer: binary search, hit check, then update, insert shift or clear.
  srss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_kind   (in_ch.kind),
    .in_column (in_ch.column),
    .in_value  (in_ch.value),
    .out_free  (!out_valid_r),
    .res_valid (res_valid),
    .res       (res),
    .req       (mem_req),
    .rd        (mem_rd)
  );

  // Column and value storage.
  srss_mem u_mem (
    .clk (clk),
    .req (mem_req),
    .rd  (mem_rd)
  );

  // Output register: holds the finished result until the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_value  = out_res_r.read_value;
  assign out_ch.found       = out_res_r.found;
  assign out_ch.overflow    = out_res_r.overflow;
  assign out_ch.entry_count = srss_pkg::COUNT_OUT_W'(out_res_r.count);

  // The stored entry count never exceeds the row capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res.count <= srss_pkg::CNT_W'(srss_pkg::ROW_CAPACITY))
    else $error("entry count above capacity");

  // A dropped set is always of a column that was not present.
  a_ovf_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.overflow && out_ch.found))
    else $error("overflow reported for a present column");

  // A nonzero read value only comes from a hit.
  a_value_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.read_value != '0)) |-> out_ch.found)
    else $error("read value without hit");

  // The sequencer is busy in the cycle after it accepts a transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("accepted twice in a row");

  // A new result never overwrites one that still waits in the output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (!out_valid_r || out_ch.ready))
    else $error("result overwritten");

endmodule
